[design/adac_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and defaults for the audio DAC with sample FIFO.
package adac_pkg;

  localparam int DEF_FIFO_DEPTH = 1024;
  localparam int DEF_MAX_DRAIN  = 64;

  localparam logic [15:0] PERIOD_RESET = 16'd256;
  localparam int          DIV_STEPS    = 17;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_DRAIN = 2'd3;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [5:0] WORD_CONTROL = 6'd0;
  localparam logic [5:0] WORD_DATA    = 6'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  byte_offset;
    logic [7:0]  write_byte;
    logic [15:0] elapsed_cycles;
    logic [6:0]  drain_limit;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         read_byte;
    logic signed [15:0] sample;
    logic               sample_valid;
    logic [6:0]         returned_count;
    logic               last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic push;
    logic pop;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drain_nonempty;
    logic div_last;
    logic push_done;
    logic pop_last;
  } sts_t;

endpackage

[design/audio_dac_with_sample_fifo.sv]
`timescale 1ns / 1ps
// Top level of the audio DAC peripheral with its sample FIFO.
//
// Usage:
//   Issue a transaction by raising start with the item on 'item'; it is taken
//   at a clock edge where busy is low. Modes: byte read, byte write, tick,
//   drain. Results come out on 'result', each for one cycle with
//   result_valid high; the receiver cannot stall them, so sample them then.
//   - Byte read: one result in the cycle after acceptance, busy stays low.
//   - Byte write: no result, next transaction may follow immediately.
//   - Tick: a 17-step restoring divider splits accumulator plus elapsed
//     cycles into whole periods and remainder, then pushes one sample per
//     cycle, stopping when the due count runs out or the FIFO fills.
//     Samples beyond a full FIFO drop.
//   - Drain: pops one entry per cycle through the store's registered read
//     port, so each result follows its pop, one per cycle.
//     An empty drain answers with a single result in the next cycle.
//   The user must write the sample period via cfg_we/cfg_wdata only while
//   idle; the block does not enforce it. Synchronous reset clears the
//   register window, accumulator, pointers and fill count and loads a
//   period of 256. The store itself is not cleared.
module audio_dac_with_sample_fifo #(
  parameter int FIFO_DEPTH = adac_pkg::DEF_FIFO_DEPTH,
  parameter int MAX_DRAIN  = adac_pkg::DEF_MAX_DRAIN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  adac_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  output logic              result_valid,
  output adac_pkg::result_t result
);

  adac_pkg::cmd_t cmd;
  adac_pkg::sts_t sts;

  // Sequence the work
  adac_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mode (item.mode),
    .sts  (sts),
    .busy (busy),
    .cmd  (cmd)
  );

  // Hold the registers, divider, FIFO and result staging
  adac_dp #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .MAX_DRAIN (MAX_DRAIN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item        (item),
    .cmd         (cmd),
    .sts         (sts),
    .result_valid(result_valid),
    .result      (result)
  );

  // An accepted read answers in the next cycle as a final read result
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.mode == adac_pkg::MODE_READ |=>
      result_valid && result.result_kind == adac_pkg::KIND_READ && result.last)
    else $error("read transaction did not answer in the next cycle");

  // A tick always spends time in the divider
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.mode == adac_pkg::MODE_TICK |=> busy)
    else $error("tick transaction did not start the divider");

  // Drain samples come back to back until the last one
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == adac_pkg::KIND_DRAIN && !result.last |=>
      result_valid && result.result_kind == adac_pkg::KIND_DRAIN && result.sample_valid)
    else $error("drain run broke before its last sample");

  // A write never makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.mode == adac_pkg::MODE_WRITE |=> !busy && !result_valid)
    else $error("write transaction produced activity");

endmodule

[design/adac_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module adac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/adac_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences ticks (divide, push) and drains.
module adac_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         mode,
  input  adac_pkg::sts_t     sts,
  output logic               busy,
  output adac_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_DRAIN
  } state_t;

  state_t state;
  logic   accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.div_step = (state == ST_DIV);
    cmd.push     = (state == ST_PUSH) && !sts.push_done;
    cmd.pop      = (state == ST_DRAIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && mode == adac_pkg::MODE_TICK) begin
            state <= ST_DIV;
          end else if (accept && mode == adac_pkg::MODE_DRAIN && sts.drain_nonempty) begin
            state <= ST_DRAIN;
          end
        end
        ST_DIV: begin
          if (sts.div_last) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (sts.push_done) begin
            state <= ST_IDLE;
          end
        end
        ST_DRAIN: begin
          if (sts.pop_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/adac_dp.sv]
`timescale 1ns / 1ps
// Datapath: register window, period divider, FIFO pointers and result staging.
module adac_dp #(
  parameter int FIFO_DEPTH = adac_pkg::DEF_FIFO_DEPTH,
  parameter int MAX_DRAIN  = adac_pkg::DEF_MAX_DRAIN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  adac_pkg::item_t   item,
  input  adac_pkg::cmd_t    cmd,
  output adac_pkg::sts_t    sts,
  output logic              result_valid,
  output adac_pkg::result_t result
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int FW = $clog2(FIFO_DEPTH + 1);
  localparam int CW = (FW > 7) ? FW : 7;
  localparam int DCW = $clog2(adac_pkg::DIV_STEPS);

  logic [15:0] sample_period;
  logic [31:0] control_word;
  logic [31:0] data_word;
  logic [15:0] tick_residue;
  logic [AW-1:0] write_pointer;
  logic [AW-1:0] read_pointer;
  logic [FW-1:0] fill_count;

  logic [15:0]    div_rem;
  logic [16:0]    div_q;
  logic [DCW-1:0] div_cnt;

  logic [6:0] remaining;
  logic [6:0] ret_count;
  logic       pop_vld;
  logic       pop_last;
  logic       out_valid;
  adac_pkg::result_t out_data;

  logic [15:0] period_eff;
  logic [15:0] held_sample;
  logic [15:0] push_value;
  logic [16:0] tick_sum;
  logic [16:0] trial;
  logic        trial_ge;
  logic [16:0] trial_diff;
  logic [15:0] rem_next;
  logic [6:0]  want;
  logic [6:0]  drain_count;
  logic [31:0] read_word;
  logic [7:0]  read_byte;
  logic [31:0] byte_mask;
  logic [31:0] byte_value;
  logic        fifo_full;
  logic [15:0] ram_q;

  assign period_eff  = (sample_period == 16'd0) ? 16'd1 : sample_period;
  // Signed 10-bit field times 64 is that field left in place
  assign held_sample = {data_word[15:6], 6'd0};
  assign push_value  = control_word[0] ? held_sample : 16'd0;
  assign tick_sum    = {1'b0, tick_residue} + {1'b0, item.elapsed_cycles};

  assign trial      = {div_rem, div_q[16]};
  assign trial_ge   = (trial >= {1'b0, period_eff});
  assign trial_diff = trial - {1'b0, period_eff};
  assign rem_next   = trial_ge ? trial_diff[15:0] : trial[15:0];

  assign want = (item.drain_limit > 7'(MAX_DRAIN)) ? 7'(MAX_DRAIN) : item.drain_limit;
  assign drain_count = (CW'(want) <= CW'(fill_count)) ? want : 7'(fill_count);

  assign fifo_full = (fill_count == FW'(FIFO_DEPTH));

  always_comb begin
    if (item.byte_offset[7:2] == adac_pkg::WORD_CONTROL) begin
      read_word = control_word;
    end else if (item.byte_offset[7:2] == adac_pkg::WORD_DATA) begin
      read_word = data_word;
    end else begin
      read_word = 32'd0;
    end
    case (item.byte_offset[1:0])
      2'd0:    read_byte = read_word[7:0];
      2'd1:    read_byte = read_word[15:8];
      2'd2:    read_byte = read_word[23:16];
      default: read_byte = read_word[31:24];
    endcase
    byte_mask  = 32'hFF << {item.byte_offset[1:0], 3'd0};
    byte_value = {24'd0, item.write_byte} << {item.byte_offset[1:0], 3'd0};
  end

  always_comb begin
    sts                = '0;
    sts.drain_nonempty = (drain_count != 7'd0);
    sts.div_last       = (div_cnt == DCW'(adac_pkg::DIV_STEPS - 1));
    sts.push_done      = (div_q == 17'd0) || fifo_full;
    sts.pop_last       = (remaining == 7'd1);
  end

  adac_ram #(
    .WIDTH(16),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(write_pointer),
    .wdata(push_value),
    .re   (cmd.pop),
    .raddr(read_pointer),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period     <= adac_pkg::PERIOD_RESET;
      control_word      <= 32'd0;
      data_word         <= 32'd0;
      tick_residue      <= 16'd0;
      write_pointer     <= '0;
      read_pointer      <= '0;
      fill_count        <= '0;
      div_cnt           <= '0;
      remaining         <= 7'd0;
      pop_vld           <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      // Flag a read answer or an empty drain answer for the next cycle
      out_valid <= cmd.accept && ((item.mode == adac_pkg::MODE_READ) ||
                   (item.mode == adac_pkg::MODE_DRAIN && drain_count == 7'd0));
      pop_vld   <= cmd.pop;
      if (cfg_we) begin
        sample_period <= cfg_wdata;
      end
      if (cmd.accept) begin
        case (item.mode)
          adac_pkg::MODE_READ: begin
            out_data <= '{adac_pkg::KIND_READ, read_byte, 16'sd0, 1'b0, 7'd0, 1'b1};
          end
          adac_pkg::MODE_WRITE: begin
            if (item.byte_offset[7:2] == adac_pkg::WORD_CONTROL) begin
              control_word <= (control_word & ~byte_mask) | byte_value;
            end else if (item.byte_offset[7:2] == adac_pkg::WORD_DATA) begin
              data_word <= (data_word & ~byte_mask) | byte_value;
            end
          end
          adac_pkg::MODE_TICK: begin
            div_q   <= tick_sum;
            div_rem <= 16'd0;
            div_cnt <= '0;
          end
          default: begin
            remaining <= drain_count;
            ret_count <= drain_count;
            if (drain_count == 7'd0) begin
              out_data <= '{adac_pkg::KIND_DRAIN, 8'd0, 16'sd0, 1'b0, 7'd0, 1'b1};
            end
          end
        endcase
      end
      // One quotient bit per step, restoring
      if (cmd.div_step) begin
        div_rem <= rem_next;
        div_q   <= {div_q[15:0], trial_ge};
        div_cnt <= div_cnt + DCW'(1);
        if (sts.div_last) begin
          tick_residue <= rem_next;
        end
      end
      // Quotient doubles as the count of samples still due
      if (cmd.push) begin
        write_pointer <= (write_pointer == AW'(FIFO_DEPTH - 1)) ? '0 : write_pointer + AW'(1);
        fill_count    <= fill_count + FW'(1);
        div_q         <= div_q - 17'd1;
      end
      if (cmd.pop) begin
        read_pointer <= (read_pointer == AW'(FIFO_DEPTH - 1)) ? '0 : read_pointer + AW'(1);
        fill_count   <= fill_count - FW'(1);
        remaining    <= remaining - 7'd1;
        pop_last     <= sts.pop_last;
      end
    end
  end

  always_comb begin
    result_valid = out_valid || pop_vld;
    if (pop_vld) begin
      result                = '0;
      result.result_kind    = adac_pkg::KIND_DRAIN;
      result.sample         = ram_q;
      result.sample_valid   = 1'b1;
      result.returned_count = ret_count;
      result.last           = pop_last;
    end else begin
      result = out_data;
    end
  end

endmodule

[tb/sv/audio_dac_with_sample_fifo_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the audio DAC peripheral and its sample FIFO.
module audio_dac_with_sample_fifo_tb;

  localparam int FIFO_SLOTS    = adac_pkg::DEF_FIFO_DEPTH;
  localparam int DRAIN_CAP     = adac_pkg::DEF_MAX_DRAIN;
  // Longest silent stretch: a tick runs the divider, then may push a full FIFO.
  localparam int SETTLE_CYCLES = 1100;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PHASE_ITEMS   = 75;
  localparam int REPORT_MAX    = 10;
  localparam int IDLE_PERCENT  = 27;

  // Results that can be typed in directly: a read of a zero byte, an empty drain.
  localparam adac_pkg::result_t READ_ZERO =
    '{adac_pkg::KIND_READ, 8'h00, 16'sd0, 1'b0, 7'd0, 1'b1};
  localparam adac_pkg::result_t EMPTY_DRAIN =
    '{adac_pkg::KIND_DRAIN, 8'h00, 16'sd0, 1'b0, 7'd0, 1'b1};

  typedef struct {
    adac_pkg::item_t   it;
    bit                typed;
    adac_pkg::result_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  adac_pkg::item_t   item = '0;
  logic              cfg_we = 1'b0;
  logic [15:0]       cfg_wdata = 16'd0;
  logic              result_valid;
  adac_pkg::result_t result;

  // Shadow copy of the peripheral state, advanced once per accepted transaction.
  logic [15:0] period_reg = adac_pkg::PERIOD_RESET;
  logic [31:0] ctrl_word = '0;
  logic [31:0] data_word = '0;
  logic [15:0] held_smp = '0;
  logic [15:0] cycle_acc = '0;
  int          wr_ptr = 0;
  int          rd_ptr = 0;
  int          fill = 0;
  logic [15:0] fifo_mem [FIFO_SLOTS];

  adac_pkg::result_t expected_results [$];
  adac_pkg::result_t exp_head;
  dir_row_t          dir_table [$];
  int                mismatches = 0;
  longint            cycle_count = 0;
  logic [15:0]       phase_periods [6];

  audio_dac_with_sample_fifo dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic string fmt_result(input adac_pkg::result_t r);
    return $sformatf("kind=%0d byte=%02h sample=%0d valid=%0b count=%0d last=%0b",
                     r.result_kind, r.read_byte, r.sample, r.sample_valid,
                     r.returned_count, r.last);
  endfunction

  // Work out the results of one accepted transaction and queue them in order.
  function automatic void predict(input adac_pkg::item_t it);
    logic [5:0]        word_idx;
    logic [4:0]        shift;
    logic [31:0]       word_v;
    logic [31:0]       mask;
    logic [15:0]       push_val;
    int                sum_i;
    int                eff;
    int                due;
    int                n;
    int                want;
    int                count;
    adac_pkg::result_t r;
    word_idx = it.byte_offset[7:2];
    shift    = {it.byte_offset[1:0], 3'b000};
    case (it.mode)
      adac_pkg::MODE_READ: begin
        if (word_idx == adac_pkg::WORD_CONTROL) word_v = ctrl_word;
        else if (word_idx == adac_pkg::WORD_DATA) word_v = data_word;
        else word_v = '0;
        r = '{adac_pkg::KIND_READ, 8'(word_v >> shift), 16'sd0, 1'b0, 7'd0, 1'b1};
        expected_results.push_back(r);
      end
      adac_pkg::MODE_WRITE: begin
        mask = 32'hFF << shift;
        if (word_idx == adac_pkg::WORD_CONTROL) begin
          ctrl_word = (ctrl_word & ~mask) | (32'(it.write_byte) << shift);
        end else if (word_idx == adac_pkg::WORD_DATA) begin
          data_word = (data_word & ~mask) | (32'(it.write_byte) << shift);
          // Signed 10-bit field times 64 lands back on bits 15..6.
          held_smp  = {data_word[15:6], 6'b000000};
        end
      end
      adac_pkg::MODE_TICK: begin
        eff      = (period_reg == 16'd0) ? 1 : int'(period_reg);
        sum_i    = int'(cycle_acc) + int'(it.elapsed_cycles);
        due      = sum_i / eff;
        n        = (due < FIFO_SLOTS - fill) ? due : FIFO_SLOTS - fill;
        // Reduce the accumulator by every whole period, even those dropped.
        cycle_acc = 16'(sum_i % eff);
        push_val  = ctrl_word[0] ? held_smp : 16'd0;
        for (int i = 0; i < n; i++) begin
          fifo_mem[wr_ptr] = push_val;
          wr_ptr = (wr_ptr + 1) % FIFO_SLOTS;
          fill++;
        end
      end
      default: begin
        want  = (int'(it.drain_limit) > DRAIN_CAP) ? DRAIN_CAP : int'(it.drain_limit);
        count = (want < fill) ? want : fill;
        if (count == 0) begin
          expected_results.push_back(EMPTY_DRAIN);
        end else begin
          for (int i = 0; i < count; i++) begin
            r = '{adac_pkg::KIND_DRAIN, 8'h00, fifo_mem[rd_ptr], 1'b1, 7'(count),
                  1'(i == count - 1)};
            expected_results.push_back(r);
            rd_ptr = (rd_ptr + 1) % FIFO_SLOTS;
          end
          fill -= count;
        end
      end
    endcase
  endfunction

  function automatic dir_row_t row(input logic [1:0] m, input int off, input int wb,
                                   input int el, input int mx);
    dir_row_t d;
    d.it    = '{m, 8'(off), 8'(wb), 16'(el), 7'(mx)};
    d.typed = 1'b0;
    d.want  = '0;
    return d;
  endfunction

  function automatic dir_row_t row_chk(input logic [1:0] m, input int off, input int mx,
                                       input adac_pkg::result_t want);
    dir_row_t d;
    d       = row(m, off, 0, 0, mx);
    d.typed = 1'b1;
    d.want  = want;
    return d;
  endfunction

  // Random transaction: mostly register offsets 0..7 and elapsed counts near a few
  // periods, so ticks fill the FIFO at a pace that drains can keep up with.
  function automatic adac_pkg::item_t rand_item();
    adac_pkg::item_t it;
    int              eff;
    int              span;
    int              pick;
    eff  = (period_reg == 16'd0) ? 1 : int'(period_reg);
    span = (3 * eff > 65535) ? 65535 : 3 * eff;
    it.byte_offset    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 7));
    it.write_byte     = 8'($urandom);
    it.elapsed_cycles = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, span));
    it.drain_limit    = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(1, DRAIN_CAP));
    pick = $urandom_range(0, 99);
    if (pick < 20) it.mode = adac_pkg::MODE_READ;
    else if (pick < 45) it.mode = adac_pkg::MODE_WRITE;
    else if (pick < 75) it.mode = adac_pkg::MODE_TICK;
    else it.mode = adac_pkg::MODE_DRAIN;
    return it;
  endfunction

  // Offer one transaction, hold it until accepted, then predict it.
  // Start stays high across back-to-back transactions.
  task automatic send(input adac_pkg::item_t it, input bit typed,
                      input adac_pkg::result_t want, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    predict(it);
    // Swap in the hand-written expectation for rows that carry one.
    if (typed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
  endtask

  // Let the block go quiet, then load a new sample period.
  task automatic write_period(input logic [15:0] value);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    period_reg  = value;
  endtask

  // Check every result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result %s", $time, fmt_result(result));
      end else begin
        exp_head = expected_results.pop_front();
        if (result.result_kind !== exp_head.result_kind ||
            result.read_byte !== exp_head.read_byte ||
            result.sample !== exp_head.sample ||
            result.sample_valid !== exp_head.sample_valid ||
            result.returned_count !== exp_head.returned_count ||
            result.last !== exp_head.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: mismatch, expected %s, got %s", $time,
                     fmt_result(exp_head), fmt_result(result));
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // Directed transactions at the reset period of 256.
    dir_table.push_back(row_chk(adac_pkg::MODE_READ, 0, 0, READ_ZERO));
    dir_table.push_back(row_chk(adac_pkg::MODE_DRAIN, 0, 5, EMPTY_DRAIN));
    dir_table.push_back(row(adac_pkg::MODE_WRITE, 0, 8'h01, 0, 0));
    dir_table.push_back(row(adac_pkg::MODE_WRITE, 4, 8'hC0, 0, 0));
    dir_table.push_back(row(adac_pkg::MODE_WRITE, 5, 8'h80, 0, 0));
    // Offsets past the data word ignore writes and read zero.
    dir_table.push_back(row(adac_pkg::MODE_WRITE, 8, 8'hFF, 0, 0));
    dir_table.push_back(row_chk(adac_pkg::MODE_READ, 8, 0, READ_ZERO));
    dir_table.push_back(row_chk(adac_pkg::MODE_READ, 255, 0, READ_ZERO));
    dir_table.push_back(row(adac_pkg::MODE_READ, 5, 0, 0, 0));
    dir_table.push_back(row(adac_pkg::MODE_TICK, 0, 0, 255, 0));
    dir_table.push_back(row(adac_pkg::MODE_TICK, 0, 0, 1, 0));
    // Zero request with samples waiting still answers with the empty result.
    dir_table.push_back(row_chk(adac_pkg::MODE_DRAIN, 0, 0, EMPTY_DRAIN));
    dir_table.push_back(row(adac_pkg::MODE_DRAIN, 0, 0, 0, 1));
    dir_table.push_back(row(adac_pkg::MODE_TICK, 0, 0, 65535, 0));
    dir_table.push_back(row(adac_pkg::MODE_WRITE, 7, 8'hFF, 0, 0));
    // Sample 0x7F40 (field 509), then the enable cleared so zeros are pushed.
    dir_table.push_back(row(adac_pkg::MODE_WRITE, 4, 8'h40, 0, 0));
    dir_table.push_back(row(adac_pkg::MODE_WRITE, 5, 8'h7F, 0, 0));
    dir_table.push_back(row(adac_pkg::MODE_TICK, 0, 0, 65535, 0));
    dir_table.push_back(row(adac_pkg::MODE_WRITE, 0, 8'h00, 0, 0));
    dir_table.push_back(row(adac_pkg::MODE_TICK, 0, 0, 65535, 0));
    // Fill the FIFO to the top; the last tick drops nearly all it owes.
    dir_table.push_back(row(adac_pkg::MODE_TICK, 0, 0, 65535, 0));
    dir_table.push_back(row(adac_pkg::MODE_TICK, 0, 0, 65535, 0));
    // Oversized request is cut to the drain cap.
    dir_table.push_back(row(adac_pkg::MODE_DRAIN, 0, 0, 0, 127));
    dir_table.push_back(row(adac_pkg::MODE_DRAIN, 0, 0, 0, 64));
    dir_table.push_back(row(adac_pkg::MODE_READ, 4, 0, 0, 0));

    // Periods per random phase: both extremes, zero acting as one, odd values.
    phase_periods[0] = 16'd1;
    phase_periods[1] = 16'd65535;
    phase_periods[2] = 16'd0;
    phase_periods[3] = 16'd3;
    phase_periods[4] = 16'd700;
    phase_periods[5] = 16'($urandom_range(2, 2000));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i])
      send(dir_table[i].it, dir_table[i].typed, dir_table[i].want, 1'b1);

    foreach (phase_periods[p]) begin
      write_period(phase_periods[p]);
      // Phase 3 runs back to back with no idle cycles at all.
      for (int k = 0; k < PHASE_ITEMS; k++)
        send(rand_item(), 1'b0, READ_ZERO, p != 3);
    end

    // Drain outstanding results, then give a late tick time to misbehave.
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
